>>> design/nqp_pkg.sv
package nqp_pkg;

  localparam int VBITS = 31;

  typedef struct packed {
    logic zero;
    logic [VBITS-1:0] mag_x;
    logic [VBITS-1:0] mag_y;
    logic [VBITS-1:0] mag_z;
    logic [VBITS-1:0] mag_w;
    logic [3:0] neg;
  } nqp_item_t;

endpackage

>>> design/nqp_front.sv
module nqp_front #(
  parameter int CB = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [CB-1:0] lx,
  input  logic signed [CB-1:0] ly,
  input  logic signed [CB-1:0] lz,
  input  logic signed [CB-1:0] lw,
  input  logic signed [CB-1:0] rx,
  input  logic signed [CB-1:0] ry,
  input  logic signed [CB-1:0] rz,
  input  logic signed [CB-1:0] rw,
  output logic out_valid,
  output nqp_pkg::nqp_item_t item
);
  import nqp_pkg::*;

  localparam int PW = 2 * CB;
  localparam int SW = 2 * CB + 2;
  localparam int BW = $clog2(SW + 1);

  logic signed [PW-1:0] t [16];
  logic v1;
  logic signed [SW-1:0] p [4];
  logic v2;
  logic signed [SW-1:0] p_in [4];
  logic [SW-1:0] a [4];
  logic [SW-1:0] m;
  logic [BW-1:0] b;
  logic [SW-1:0] sh [4];
  logic signed [SW-1:0] fl [4];
  nqp_item_t item_next;

  always_ff @(posedge clk) begin
    t[0] <= rw * lx;  t[1] <= rx * lw;  t[2] <= ry * lz;  t[3] <= rz * ly;
    t[4] <= rw * ly;  t[5] <= ry * lw;  t[6] <= rz * lx;  t[7] <= rx * lz;
    t[8] <= rw * lz;  t[9] <= rz * lw;  t[10] <= rx * ly; t[11] <= ry * lx;
    t[12] <= rw * lw; t[13] <= rx * lx; t[14] <= ry * ly; t[15] <= rz * lz;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (i == 3) begin
        p[i] <= SW'(t[12]) - SW'(t[13]) - SW'(t[14]) - SW'(t[15]);
      end else begin
        p[i] <= SW'(t[4*i]) + SW'(t[4*i+1]) + SW'(t[4*i+2]) - SW'(t[4*i+3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_comb begin
    m = '0;
    b = '0;
    for (int i = 0; i < 4; i++) begin
      p_in[i] = p[i];
      a[i] = p[i][SW-1] ? SW'(-p[i]) : SW'(p[i]);
      m = m | a[i];
    end
    for (int k = 0; k < SW; k++) begin
      if (m[k]) b = BW'(k + 1);
    end
    item_next.zero = (m == '0);
    for (int i = 0; i < 4; i++) begin
      if (b > BW'(30)) begin
        fl[i] = p_in[i] >>> (b - BW'(30));
      end else begin
        fl[i] = p_in[i] <<< (BW'(30) - b);
      end
      sh[i] = fl[i][SW-1] ? SW'(-fl[i]) : SW'(fl[i]);
      item_next.neg[i] = fl[i][SW-1];
    end
    item_next.mag_x = sh[0][VBITS-1:0];
    item_next.mag_y = sh[1][VBITS-1:0];
    item_next.mag_z = sh[2][VBITS-1:0];
    item_next.mag_w = sh[3][VBITS-1:0];
  end

  always_ff @(posedge clk) begin
    item <= item_next;
  end

endmodule

>>> design/nqp_back.sv
module nqp_back #(
  parameter int CB = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  nqp_pkg::nqp_item_t item,
  output logic out_valid,
  output logic signed [CB-1:0] ox,
  output logic signed [CB-1:0] oy,
  output logic signed [CB-1:0] oz,
  output logic signed [CB-1:0] ow,
  output logic zero
);
  import nqp_pkg::*;

  localparam int SQW = 2 * VBITS + 2;
  localparam int RW = VBITS + 1;
  localparam int NW = VBITS + CB;
  localparam int QS = 8;
  localparam int DS = NW;
  localparam int LAT = 2 + QS + DS;

  logic [SQW-1:0] sq [4];
  logic [SQW-1:0] ssum;
  nqp_item_t it1;
  nqp_item_t it2;
  logic [SQW-1:0] rr [QS+1];
  logic [SQW-1:0] rt [QS+1];
  logic [SQW-1:0] rb [QS+1];
  nqp_item_t iq [QS+1];
  logic [NW-1:0] dn [4][DS+1];
  logic [RW:0] dr [4][DS+1];
  logic [NW-1:0] dq [4][DS+1];
  logic [RW-1:0] droot [DS+1];
  logic [3:0] dneg [DS+1];
  logic dz [DS+1];
  logic [LAT:0] vp;

  always_ff @(posedge clk) begin
    sq[0] <= SQW'(item.mag_x) * SQW'(item.mag_x);
    sq[1] <= SQW'(item.mag_y) * SQW'(item.mag_y);
    sq[2] <= SQW'(item.mag_z) * SQW'(item.mag_z);
    sq[3] <= SQW'(item.mag_w) * SQW'(item.mag_w);
    it1 <= item;
    ssum <= sq[0] + sq[1] + sq[2] + sq[3];
    it2 <= it1;
  end

  always_comb begin
    rr[0] = ssum;
    rt[0] = '0;
    rb[0] = SQW'(1) << (SQW - 2);
    iq[0] = it2;
  end

  for (genvar s = 0; s < QS; s++) begin : g_sqrt
    logic [SQW-1:0] n_c;
    logic [SQW-1:0] r_c;
    logic [SQW-1:0] b_c;
    always_comb begin
      n_c = rr[s];
      r_c = rt[s];
      b_c = rb[s];
      for (int j = 0; j < SQW / (2 * QS); j++) begin
        if (b_c != '0) begin
          if (n_c >= r_c + b_c) begin
            n_c = n_c - (r_c + b_c);
            r_c = (r_c >> 1) + b_c;
          end else begin
            r_c = r_c >> 1;
          end
          b_c = b_c >> 2;
        end
      end
    end
    always_ff @(posedge clk) begin
      rr[s+1] <= n_c;
      rt[s+1] <= r_c;
      rb[s+1] <= b_c;
      iq[s+1] <= iq[s];
    end
  end

  always_comb begin
    dn[0][0] = NW'(iq[QS].mag_x) << (CB - 2);
    dn[1][0] = NW'(iq[QS].mag_y) << (CB - 2);
    dn[2][0] = NW'(iq[QS].mag_z) << (CB - 2);
    dn[3][0] = NW'(iq[QS].mag_w) << (CB - 2);
    for (int i = 0; i < 4; i++) begin
      dn[i][0] = dn[i][0] + NW'(rt[QS] >> 1);
      dr[i][0] = '0;
      dq[i][0] = '0;
    end
    droot[0] = rt[QS][RW-1:0];
    dneg[0] = iq[QS].neg;
    dz[0] = iq[QS].zero;
  end

  for (genvar s = 0; s < DS; s++) begin : g_div
    logic [RW:0] sr [4];
    logic [RW:0] df [4];
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        sr[i] = {dr[i][s][RW-1:0], dn[i][s][NW-1-s]};
        df[i] = sr[i] - {1'b0, droot[s]};
      end
    end
    always_ff @(posedge clk) begin
      for (int i = 0; i < 4; i++) begin
        dn[i][s+1] <= dn[i][s];
        if (sr[i] >= {1'b0, droot[s]}) begin
          dr[i][s+1] <= df[i];
          dq[i][s+1] <= {dq[i][s][NW-2:0], 1'b1};
        end else begin
          dr[i][s+1] <= sr[i];
          dq[i][s+1] <= {dq[i][s][NW-2:0], 1'b0};
        end
      end
      droot[s+1] <= droot[s];
      dneg[s+1] <= dneg[s];
      dz[s+1] <= dz[s];
    end
  end

  function automatic logic [CB-1:0] sat(input logic [NW-1:0] r, input logic n, input logic z);
    logic [CB-1:0] res;
    if (z) begin
      res = '0;
    end else if (n) begin
      if (r >= (NW'(1) << (CB - 1))) res = {1'b1, {(CB-1){1'b0}}};
      else res = CB'(-r);
    end else begin
      if (r >= (NW'(1) << (CB - 1))) res = {1'b0, {(CB-1){1'b1}}};
      else res = CB'(r);
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    ox <= sat(dq[0][DS], dneg[DS][0], dz[DS]);
    oy <= sat(dq[1][DS], dneg[DS][1], dz[DS]);
    oz <= sat(dq[2][DS], dneg[DS][2], dz[DS]);
    ow <= sat(dq[3][DS], dneg[DS][3], dz[DS]);
    zero <= dz[DS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else begin
      vp <= {vp[LAT-1:0], in_valid};
    end
  end

  assign out_valid = vp[LAT];

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero |-> ox == '0 && ow == '0)
    else $error("Zero-norm beat carries nonzero data.");

  a_zero_yz: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero |-> oy == '0 && oz == '0)
    else $error("Zero-norm beat carries nonzero data.");

  a_valid_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(vp))
    else $error("Valid pipeline holds an unknown value.");

endmodule

>>> design/normalized_quaternion_product_unit.sv
// Channel  | Handshake         | Payload
// input    | start / busy      | lhs_x..lhs_w, rhs_x..rhs_w
// result   | done (one cycle)  | prod_x..prod_w, zero_norm
// One beat is accepted per cycle; busy is held low.
// Each result passes through the product, square-root and restoring-divider
// pipelines in turn.
// Reset is synchronous and clears all valid flags; the receiver cannot stall.
module normalized_quaternion_product_unit #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [COMPONENT_BITS-1:0] lhs_x,
  input  logic signed [COMPONENT_BITS-1:0] lhs_y,
  input  logic signed [COMPONENT_BITS-1:0] lhs_z,
  input  logic signed [COMPONENT_BITS-1:0] lhs_w,
  input  logic signed [COMPONENT_BITS-1:0] rhs_x,
  input  logic signed [COMPONENT_BITS-1:0] rhs_y,
  input  logic signed [COMPONENT_BITS-1:0] rhs_z,
  input  logic signed [COMPONENT_BITS-1:0] rhs_w,
  output logic done,
  output logic signed [COMPONENT_BITS-1:0] prod_x,
  output logic signed [COMPONENT_BITS-1:0] prod_y,
  output logic signed [COMPONENT_BITS-1:0] prod_z,
  output logic signed [COMPONENT_BITS-1:0] prod_w,
  output logic zero_norm
);
  import nqp_pkg::*;

  logic fv;
  nqp_item_t fitem;

  assign busy = 1'b0;

  nqp_front #(.CB(COMPONENT_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(start),
    .lx(lhs_x), .ly(lhs_y), .lz(lhs_z), .lw(lhs_w),
    .rx(rhs_x), .ry(rhs_y), .rz(rhs_z), .rw(rhs_w),
    .out_valid(fv), .item(fitem)
  );

  nqp_back #(.CB(COMPONENT_BITS)) u_back (
    .clk(clk), .rst(rst), .in_valid(fv), .item(fitem),
    .out_valid(done), .ox(prod_x), .oy(prod_y), .oz(prod_z), .ow(prod_w),
    .zero(zero_norm)
  );

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("Busy raised on a block that takes a beat every cycle.");

endmodule

>>> test/testbench.sv
module testbench;

  localparam int CB = 16;
  localparam int FRAC = CB - 2;
  localparam int LATENCY = 80;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic signed [CB-1:0] w;
    logic zero;
  } quat_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CB-1:0] lhs_x = '0, lhs_y = '0, lhs_z = '0, lhs_w = '0;
  logic signed [CB-1:0] rhs_x = '0, rhs_y = '0, rhs_z = '0, rhs_w = '0;
  logic done;
  logic signed [CB-1:0] prod_x, prod_y, prod_z, prod_w;
  logic zero_norm;

  quat_res_t expected_products[$];
  int error_count = 0;
  int reported = 0;

  always #6 clk = ~clk;

  normalized_quaternion_product_unit #(.COMPONENT_BITS(CB)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .lhs_x(lhs_x), .lhs_y(lhs_y), .lhs_z(lhs_z), .lhs_w(lhs_w),
    .rhs_x(rhs_x), .rhs_y(rhs_y), .rhs_z(rhs_z), .rhs_w(rhs_w),
    .done(done), .prod_x(prod_x), .prod_y(prod_y), .prod_z(prod_z),
    .prod_w(prod_w), .zero_norm(zero_norm)
  );

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Hamilton product rhs*lhs, scaled to unit length and clamped.
  function automatic quat_res_t normalized_product(
      input logic signed [CB-1:0] lx, ly, lz, lw, rx, ry, rz, rw);
    quat_res_t r;
    longint p[4];
    longint v[4];
    longint unsigned mg, mx, sum, root, quo, num;
    int blen;
    p[0] = rw * lx + rx * lw + ry * lz - rz * ly;
    p[1] = rw * ly + ry * lw + rz * lx - rx * lz;
    p[2] = rw * lz + rz * lw + rx * ly - ry * lx;
    p[3] = rw * lw - rx * lx - ry * ly - rz * lz;
    r = '{default: '0};
    if (p[0] == 0 && p[1] == 0 && p[2] == 0 && p[3] == 0) begin
      r.zero = 1'b1;
      return r;
    end
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      mg = (p[i] < 0) ? -p[i] : p[i];
      if (mg > mx) mx = mg;
    end
    blen = 0;
    while (blen < 64 && (mx >> blen) != 0) blen++;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      if (blen > 30) v[i] = p[i] >>> (blen - 30);
      else v[i] = p[i] <<< (30 - blen);
      mg = (v[i] < 0) ? -v[i] : v[i];
      sum = sum + mg * mg;
    end
    root = isqrt(sum);
    for (int i = 0; i < 4; i++) begin
      logic signed [CB-1:0] c;
      mg = (v[i] < 0) ? -v[i] : v[i];
      num = (mg << FRAC) + (root >> 1);
      quo = (root != 0) ? num / root : 0;
      if (v[i] < 0) c = (quo > (64'd1 << (CB - 1))) ? {1'b1, {(CB-1){1'b0}}} : -quo;
      else c = (quo > ((64'd1 << (CB - 1)) - 1)) ? {1'b0, {(CB-1){1'b1}}} : quo;
      case (i)
        0: r.x = c;
        1: r.y = c;
        2: r.z = c;
        default: r.w = c;
      endcase
    end
    return r;
  endfunction

  task automatic send_quats(input logic [CB-1:0] lx, ly, lz, lw, rx, ry, rz, rw);
    start <= 1'b1;
    lhs_x <= lx; lhs_y <= ly; lhs_z <= lz; lhs_w <= lw;
    rhs_x <= rx; rhs_y <= ry; rhs_z <= rz; rhs_w <= rw;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_products.push_back(normalized_product(lx, ly, lz, lw, rx, ry, rz, rw));
  endtask

  task automatic pause_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(CB-1){1'b0}}};
      1: return {1'b0, {(CB-1){1'b1}}};
      2: return $urandom_range(0, 3) - 1;
      3: return 1 << FRAC;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [CB-1:0] mn, mp, one;
    mn = {1'b1, {(CB-1){1'b0}}};
    mp = {1'b0, {(CB-1){1'b1}}};
    one = 1 << FRAC;
    send_quats(0, 0, 0, one, 0, 0, 0, one);
    send_quats(0, 0, 0, 0, 0, 0, 0, 0);
    send_quats(one, 0, 0, 0, 0, 0, 0, 0);
    send_quats(mn, mn, mn, mn, mn, mn, mn, mn);
    send_quats(mp, mp, mp, mp, mp, mp, mp, mp);
    send_quats(mn, mp, mn, mp, mp, mn, mp, mn);
    send_quats(1, 0, 0, 0, 0, 0, 0, 1);
    send_quats(0, 0, 0, 1, 0, 0, 0, 1);
    send_quats(one, 0, 0, 0, 0, one, 0, 0);
    send_quats(0, one, 0, 0, 0, 0, one, 0);
    send_quats(1, 1, 0, 0, 1, -1, 0, 0);
    send_quats(16'hFFFF, 0, 0, 0, 0, 0, 0, 16'hFFFF);
    send_quats(mn, 0, 0, 0, 0, 0, 0, mn);
    send_quats(one, one, one, one, mp, 0, 0, 0);
    send_quats(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA,
               16'h5555);
    pause_cycles(1);
  endtask

  task automatic test_random();
    int left, burst;
    left = 735;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_quats(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rand_comp(), rand_comp(), rand_comp());
        left--;
      end
      if ($urandom_range(0, 2) != 0) pause_cycles($urandom_range(1, 12));
    end
    start <= 1'b0;
  endtask

  task automatic test_drain();
    start <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_products.size() == 0) begin
        error_count++;
        if (reported < 10) begin
          reported++;
          $display("unexpected beat: %0d %0d %0d %0d z=%0b",
                   prod_x, prod_y, prod_z, prod_w, zero_norm);
        end
      end else begin
        quat_res_t e;
        e = expected_products.pop_front();
        if (e.x !== prod_x || e.y !== prod_y || e.z !== prod_z || e.w !== prod_w ||
            e.zero !== zero_norm) begin
          error_count++;
          if (reported < 10) begin
            reported++;
            $display("mismatch: expected %0d %0d %0d %0d z=%0b, got %0d %0d %0d %0d z=%0b",
                     e.x, e.y, e.z, e.w, e.zero, prod_x, prod_y, prod_z, prod_w,
                     zero_norm);
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain();
    test_random();
    test_drain();
    repeat (LATENCY) @(posedge clk);
    if (error_count == 0 && expected_products.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
